[rtl/core/fl4_pkg.sv]
// Shared types, constants and helper functions for the Fletcher-4 checksum engine.
package fl4_pkg;

    localparam int WORD_W      = 32;
    localparam int ACC_W       = 64;
    localparam int WORD_FIELDS = 4;
    localparam int COUNT_W     = 3;
    localparam int N_SUMS      = 4;
    localparam int CFG_IDX_W   = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BYTE_SWAP = 3'd0,
        CFG_SEED_A    = 3'd1,
        CFG_SEED_B    = 3'd2,
        CFG_SEED_C    = 3'd3,
        CFG_SEED_D    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [WORD_W-1:0]  word_0;
        logic [WORD_W-1:0]  word_1;
        logic [WORD_W-1:0]  word_2;
        logic [WORD_W-1:0]  word_3;
        logic [COUNT_W-1:0] word_count;
        logic               first;
        logic               last;
    } t_in_req;

    typedef struct packed {
        logic [ACC_W-1:0] sum_a;
        logic [ACC_W-1:0] sum_b;
        logic [ACC_W-1:0] sum_c;
        logic [ACC_W-1:0] sum_d;
    } t_out_res;

    // Control that travels alongside the lane data.
    typedef struct packed {
        logic               vld;
        logic               first;
        logic               last;
        logic [COUNT_W-1:0] cnt;
    } t_ctl;

    function automatic logic [WORD_W-1:0] swap32(input logic [WORD_W-1:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    // k(k+1)/2
    function automatic int tri_num(input int k);
        return (k * (k + 1)) / 2;
    endfunction

    // k(k+1)(k+2)/6 for k up to WORD_FIELDS, built as a sum of triangular numbers
    function automatic int tet_num(input int k);
        int s;
        s = 0;
        for (int j = 1; j <= WORD_FIELDS; j++) begin
            if (j <= k) begin
                s = s + tri_num(j);
            end
        end
        return s;
    endfunction

endpackage

[rtl/core/fletcher4_checksum_engine.sv]
// Fletcher-4 checksum engine top level: lanes, merge tree, accumulator and output register.
//
// Input channel: i_valid / o_stall with request i_req (up to four 32-bit words,
// word_count, first, last). A request is taken at a clock edge with i_valid high
// and o_stall low. Output channel: o_valid / i_stall with o_res (sum_a..sum_d),
// produced only for requests with last set.
// Configuration: i_cfg_we writes register i_cfg_idx (byte_swap, seed_a..seed_d)
// from i_cfg_data; write only while no request is in flight.
// Throughput: one request per cycle while o_stall is low. From accept to o_valid a
// request passes one lane register, one register per merge tree level, then the
// accumulator update that loads the output register. The accumulator loop has no
// register but r_acc, which is what sets the one-request-per-cycle figure.
// Reset clears the accumulators, the configuration registers and all valid bits.
// When i_stall holds a waiting result, requests keep entering; o_stall rises
// only once another result is ready to leave the pipe and the output register
// is still occupied, and the whole pipe then holds.
module fletcher4_checksum_engine import fl4_pkg::*; #(
    parameter int LANES = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in_req               i_req,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out_res              o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ACC_W-1:0]      i_cfg_data
);

    localparam int NL     = (LANES < WORD_FIELDS) ? LANES : WORD_FIELDS;
    localparam int CW     = $clog2(NL * (NL + 1) * (NL + 2) / 6 + 1);
    localparam int SUM_W  = WORD_W + CW + $clog2(NL);
    localparam int DEPTH  = $clog2(NL);
    localparam int STAGES = DEPTH + 1;

    logic                                 r_byte_swap;
    t_out_res                             r_seed;
    t_ctl                                 r_ctl [STAGES];
    t_ctl                                 n_ctl;
    t_ctl                                 w_tail;
    logic                                 w_adv;
    logic [COUNT_W-1:0]                   w_n;
    logic [NL-1:0][COUNT_W-1:0]           w_k;
    logic [WORD_FIELDS-1:0][WORD_W-1:0]   w_words;
    logic [NL-1:0][N_SUMS-1:0][SUM_W-1:0] w_leaf;
    logic [N_SUMS-1:0][SUM_W-1:0]         w_sum;
    t_out_res                             w_acc_nxt;
    logic                                 r_out_vld;
    t_out_res                             r_out;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_swap <= 1'b0;
            r_seed      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BYTE_SWAP: r_byte_swap  <= i_cfg_data[0];
                CFG_SEED_A:    r_seed.sum_a <= i_cfg_data;
                CFG_SEED_B:    r_seed.sum_b <= i_cfg_data;
                CFG_SEED_C:    r_seed.sum_c <= i_cfg_data;
                CFG_SEED_D:    r_seed.sum_d <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Hold the pipe only when a result must leave and the output register is blocked
    assign w_tail  = r_ctl[STAGES-1];
    assign w_adv   = !(w_tail.vld && w_tail.last && r_out_vld && i_stall);
    assign o_stall = !w_adv;

    // Saturate the count at the number of lanes
    assign w_n = (i_req.word_count > COUNT_W'(NL)) ? COUNT_W'(NL) : i_req.word_count;

    always_comb begin
        for (int j = 0; j < NL; j++) begin
            w_k[j] = (w_n > COUNT_W'(j)) ? COUNT_W'(w_n - COUNT_W'(j)) : '0;
        end
    end

    assign w_words = {i_req.word_3, i_req.word_2, i_req.word_1, i_req.word_0};

    always_comb begin
        n_ctl.vld   = i_valid;
        n_ctl.first = i_req.first;
        n_ctl.last  = i_req.last;
        n_ctl.cnt   = w_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < STAGES; s++) begin
                r_ctl[s] <= '0;
            end
        end else if (w_adv) begin
            r_ctl[0] <= n_ctl;
            for (int s = 1; s < STAGES; s++) begin
                r_ctl[s] <= r_ctl[s-1];
            end
        end
    end

    for (genvar j = 0; j < NL; j++) begin : g_lane
        fl4_lane #(
            .CW    (CW),
            .SUM_W (SUM_W)
        ) u_lane (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_word (w_words[j]),
            .i_swap (r_byte_swap),
            .i_k    (w_k[j]),
            .o_term (w_leaf[j])
        );
    end

    fl4_merge #(
        .NL    (NL),
        .SUM_W (SUM_W)
    ) u_merge (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_leaf (w_leaf),
        .o_sum  (w_sum)
    );

    fl4_acc #(
        .SUM_W (SUM_W)
    ) u_acc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_adv),
        .i_ctl     (w_tail),
        .i_sum     (w_sum),
        .i_seed    (r_seed),
        .o_acc_nxt (w_acc_nxt)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv && w_tail.vld && w_tail.last) begin
            r_out_vld <= 1'b1;
        end else if (r_out_vld && !i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_tail.vld && w_tail.last) begin
            r_out <= w_acc_nxt;
        end
    end

    assign o_valid = r_out_vld;
    assign o_res   = r_out;

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_out_vld && i_stall))
        else $error("input stalled without a blocked result");

    a_result_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_tail.vld && w_tail.last) |=> o_valid)
        else $error("final request did not produce a result");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tail.vld |-> (w_tail.cnt <= COUNT_W'(NL)))
        else $error("word count exceeds lane count");

endmodule

[rtl/core/fl4_lane.sv]
// One lane: byte swap and weighting of a single word by its position coefficients.
module fl4_lane import fl4_pkg::*; #(
    parameter int CW    = 5,
    parameter int SUM_W = 39
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [WORD_W-1:0]              i_word,
    input  logic                           i_swap,
    input  logic [COUNT_W-1:0]             i_k,
    output logic [N_SUMS-1:0][SUM_W-1:0]   o_term
);

    logic [WORD_W-1:0]             w_word;
    logic                          w_act;
    logic [CW-1:0]                 w_c2;
    logic [CW-1:0]                 w_c3;
    logic [CW-1:0]                 w_c4;
    logic [N_SUMS-1:0][SUM_W-1:0]  n_term;
    logic [N_SUMS-1:0][SUM_W-1:0]  r_term;

    assign w_word = i_swap ? swap32(i_word) : i_word;
    assign w_act  = (i_k != '0);
    assign w_c2   = CW'(i_k);
    assign w_c3   = CW'(tri_num(int'(i_k)));
    assign w_c4   = CW'(tet_num(int'(i_k)));

    // k counts the words from this one to the end of the request, itself included
    always_comb begin
        n_term[0] = w_act ? SUM_W'(w_word) : '0;
        n_term[1] = SUM_W'(w_word) * SUM_W'(w_c2);
        n_term[2] = SUM_W'(w_word) * SUM_W'(w_c3);
        n_term[3] = SUM_W'(w_word) * SUM_W'(w_c4);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_term <= n_term;
        end
    end

    assign o_term = r_term;

endmodule

[rtl/core/fl4_merge.sv]
// Registered adder tree that merges the lane terms into four per-request sums.
module fl4_merge import fl4_pkg::*; #(
    parameter int NL    = 4,
    parameter int SUM_W = 39
) (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic [NL-1:0][N_SUMS-1:0][SUM_W-1:0]   i_leaf,
    output logic [N_SUMS-1:0][SUM_W-1:0]           o_sum
);

    localparam int DEPTH = $clog2(NL);
    localparam int P     = 1 << DEPTH;

    // Heap layout: node j has children 2j+1 and 2j+2, leaves from P-1 up
    logic [N_SUMS-1:0][SUM_W-1:0] w_node [2*P-1];

    for (genvar j = 0; j < P; j++) begin : g_leaf
        if (j < NL) begin : g_used
            assign w_node[P-1+j] = i_leaf[j];
        end else begin : g_pad
            assign w_node[P-1+j] = '0;
        end
    end

    for (genvar j = 0; j < P - 1; j++) begin : g_node
        logic [N_SUMS-1:0][SUM_W-1:0] r_sum;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int f = 0; f < N_SUMS; f++) begin
                    r_sum[f] <= w_node[2*j+1][f] + w_node[2*j+2][f];
                end
            end
        end

        assign w_node[j] = r_sum;
    end

    assign o_sum = w_node[0];

endmodule

[rtl/core/fl4_acc.sv]
// Accumulator stage: folds one request's merged sums into the four running sums.
module fl4_acc import fl4_pkg::*; #(
    parameter int SUM_W = 39
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  t_ctl                          i_ctl,
    input  logic [N_SUMS-1:0][SUM_W-1:0]  i_sum,
    input  t_out_res                      i_seed,
    output t_out_res                      o_acc_nxt
);

    localparam int T2_W = COUNT_W + 1;
    localparam int T3_W = COUNT_W + 2;

    t_out_res          r_acc;
    t_out_res          w_base;
    t_out_res          n_acc;
    logic [T2_W-1:0]   w_t2;
    logic [T3_W-1:0]   w_t3;

    assign w_base = i_ctl.first ? i_seed : r_acc;
    assign w_t2   = T2_W'(tri_num(int'(i_ctl.cnt)));
    assign w_t3   = T3_W'(tet_num(int'(i_ctl.cnt)));

    // Closed form of n sequential Fletcher steps; everything wraps mod 2^64
    always_comb begin
        n_acc.sum_a = w_base.sum_a + ACC_W'(i_sum[0]);
        n_acc.sum_b = w_base.sum_b + ACC_W'(w_base.sum_a * i_ctl.cnt) + ACC_W'(i_sum[1]);
        n_acc.sum_c = w_base.sum_c + ACC_W'(w_base.sum_b * i_ctl.cnt)
                    + ACC_W'(w_base.sum_a * w_t2) + ACC_W'(i_sum[2]);
        n_acc.sum_d = w_base.sum_d + ACC_W'(w_base.sum_c * i_ctl.cnt)
                    + ACC_W'(w_base.sum_b * w_t2) + ACC_W'(w_base.sum_a * w_t3)
                    + ACC_W'(i_sum[3]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_en && i_ctl.vld) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc_nxt = n_acc;

endmodule

[dv/tb_fletcher4_checksum_engine.sv]
// Self-checking testbench for the Fletcher-4 checksum engine: random and directed requests.
module tb_fletcher4_checksum_engine;
    import fl4_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 9;
    localparam int DRAIN_CYCLES    = 12;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int HOLD_CYCLES     = 400;
    localparam int RAND_PHASES     = 6;
    localparam int ITEMS_PER_PHASE = 200;
    localparam logic [WORD_W-1:0] WORD_ONES = '1;
    localparam logic [ACC_W-1:0]  ACC_ONES  = '1;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_valid    = 1'b0;
    logic                 o_stall;
    t_in_req              i_req      = '0;
    logic                 o_valid;
    logic                 i_stall    = 1'b0;
    t_out_res             o_res;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [ACC_W-1:0]     i_cfg_data = '0;

    fletcher4_checksum_engine DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Predictor state: live register copy and running sums
    logic             cfg_swap = 1'b0;
    logic [ACC_W-1:0] cfg_seed [N_SUMS] = '{default: '0};
    logic [ACC_W-1:0] run_sum  [N_SUMS] = '{default: '0};

    t_in_req  pending_req [$];
    t_out_res expected_sums [$];

    int n_pushed     = 0;
    int n_taken      = 0;
    int n_sums_seen  = 0;
    int n_errors     = 0;
    int n_zero_count = 0;
    int n_over_count = 0;
    int n_settings   = 0;

    task automatic report(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        n_errors++;
    endtask

    // Fold one accepted request into the running sums; queue the checksum on last.
    function automatic void fold_request(input t_in_req req);
        logic [WORD_W-1:0] w [WORD_FIELDS];
        logic [WORD_W-1:0] v;
        int                n;
        t_out_res          res;
        w[0] = req.word_0;
        w[1] = req.word_1;
        w[2] = req.word_2;
        w[3] = req.word_3;
        n = (req.word_count > WORD_FIELDS) ? WORD_FIELDS : int'(req.word_count);
        if (req.word_count == 0) n_zero_count++;
        if (req.word_count > WORD_FIELDS) n_over_count++;
        if (req.first) run_sum = cfg_seed;
        for (int i = 0; i < n; i++) begin
            v = cfg_swap ? {w[i][7:0], w[i][15:8], w[i][23:16], w[i][31:24]} : w[i];
            run_sum[0] = run_sum[0] + ACC_W'(v);
            run_sum[1] = run_sum[1] + run_sum[0];
            run_sum[2] = run_sum[2] + run_sum[1];
            run_sum[3] = run_sum[3] + run_sum[2];
        end
        if (req.last) begin
            res.sum_a = run_sum[0];
            res.sum_b = run_sum[1];
            res.sum_c = run_sum[2];
            res.sum_d = run_sum[3];
            expected_sums.push_back(res);
        end
    endfunction

    task automatic check_sum(input string name, input logic [ACC_W-1:0] got,
                             input logic [ACC_W-1:0] want);
        if (got !== want)
            report($sformatf("checksum %0d %s: got %h want %h", n_sums_seen, name, got, want));
    endtask

    // Request driver: bursts of random length separated by random gaps
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin : req_driver
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                fold_request(i_req);
                n_taken++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_req.size() > 0) begin
                    i_req   <= pending_req.pop_front();
                    i_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stall pattern, with one long hold-off
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    int  mode_left = 0;
    int  stall_pct = 0;

    always @(posedge i_clk) begin : sum_monitor
        t_out_res want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_sums.size() == 0) begin
                    report($sformatf("checksum with nothing expected: %h", o_res));
                end else begin
                    want = expected_sums.pop_front();
                    check_sum("sum_a", o_res.sum_a, want.sum_a);
                    check_sum("sum_b", o_res.sum_b, want.sum_b);
                    check_sum("sum_c", o_res.sum_c, want.sum_c);
                    check_sum("sum_d", o_res.sum_d, want.sum_d);
                end
                n_sums_seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (!hold_done && n_sums_seen >= 40 && pending_req.size() >= 60) begin
                // hold the output long enough for the pipe to back up into the input
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_stall  <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode_left = $urandom_range(8, 64);
                    case ($urandom_range(0, 3))
                        0:       stall_pct = 0;
                        1:       stall_pct = 25;
                        2:       stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                end else begin
                    mode_left--;
                end
                i_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long
    int idle_cycles = 0;

    always @(posedge i_clk) begin : watchdog
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("watchdog: no request or checksum moved for %0d cycles, %0d pending",
                         WATCHDOG_LIMIT, expected_sums.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ACC_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_BYTE_SWAP: cfg_swap    = data[0];
            CFG_SEED_A:    cfg_seed[0] = data;
            CFG_SEED_B:    cfg_seed[1] = data;
            CFG_SEED_C:    cfg_seed[2] = data;
            CFG_SEED_D:    cfg_seed[3] = data;
            default: ;
        endcase
    endtask

    // seed_mode: 0 zero, 1 all ones, 2 random, 3 each seed picks one of those
    task automatic set_config(input logic swap, input int seed_mode, input bit hit_unused);
        logic [ACC_W-1:0] seed;
        int               m;
        write_reg(CFG_BYTE_SWAP, {$urandom, 16'($urandom_range(0, 65535)), 15'd0, swap});
        for (int s = 0; s < N_SUMS; s++) begin
            m = (seed_mode == 3) ? $urandom_range(0, 2) : seed_mode;
            seed = (m == 0) ? '0 : (m == 1) ? ACC_ONES : {$urandom, $urandom};
            write_reg(CFG_IDX_W'(CFG_SEED_A + s), seed);
        end
        if (hit_unused)
            for (int u = CFG_SEED_D + 1; u < (1 << CFG_IDX_W); u++)
                write_reg(CFG_IDX_W'(u), {$urandom, $urandom});
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic add_req(input logic [WORD_W-1:0] w0, input logic [WORD_W-1:0] w1,
                           input logic [WORD_W-1:0] w2, input logic [WORD_W-1:0] w3,
                           input int cnt, input bit first, input bit last);
        t_in_req r;
        r.word_0     = w0;
        r.word_1     = w1;
        r.word_2     = w2;
        r.word_3     = w3;
        r.word_count = COUNT_W'(cnt);
        r.first      = first;
        r.last       = last;
        pending_req.push_back(r);
        n_pushed++;
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return WORD_ONES;
            default: return $urandom;
        endcase
    endfunction

    function automatic int rand_count();
        case ($urandom_range(0, 19))
            0:       return 0;
            1:       return $urandom_range(WORD_FIELDS + 1, (1 << COUNT_W) - 1);
            default: return $urandom_range(1, WORD_FIELDS);
        endcase
    endfunction

    // Mostly well-formed buffers; some lack first or last, some restart or emit mid-way
    task automatic queue_buffer();
        int len;
        bit opens;
        bit closes;
        len    = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        opens  = ($urandom_range(0, 9) != 0);
        closes = ($urandom_range(0, 11) != 0);
        for (int k = 0; k < len; k++)
            add_req(rand_word(), rand_word(), rand_word(), rand_word(), rand_count(),
                    (k == 0 && opens) || ($urandom_range(0, 29) == 0),
                    (k == len - 1 && closes) || ($urandom_range(0, 39) == 0));
    endtask

    task automatic wait_idle();
        while (n_taken != n_pushed || expected_sums.size() != 0) @(posedge i_clk);
        // requests without last may still be in the pipe
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int target;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: no seed load before data, continuation, zero and oversize counts
        add_req(WORD_ONES, WORD_ONES, WORD_ONES, WORD_ONES, 4, 0, 1);
        add_req(32'h0000_0001, '0, '0, '0, 1, 0, 1);
        add_req(WORD_ONES, WORD_ONES, WORD_ONES, WORD_ONES, 0, 1, 1);
        add_req('0, '0, '0, '0, 4, 1, 0);
        add_req(WORD_ONES, 32'h8000_0000, 32'h0000_0001, 32'h1234_5678, 7, 0, 0);
        add_req(32'hDEAD_BEEF, WORD_ONES, '0, 32'h7FFF_FFFF, 5, 0, 0);
        add_req(32'hA5A5_A5A5, 32'h5A5A_5A5A, WORD_ONES, WORD_ONES, 6, 0, 1);
        add_req(32'hA5A5_A5A5, 32'h5A5A_5A5A, WORD_ONES, '0, 2, 1, 1);
        add_req(WORD_ONES, WORD_ONES, WORD_ONES, WORD_ONES, 3, 1, 0);
        add_req(32'h0102_0304, 32'h0506_0708, 32'h090A_0B0C, 32'h0D0E_0F10, 4, 1, 1);
        add_req(WORD_ONES, WORD_ONES, WORD_ONES, WORD_ONES, 0, 0, 1);
        add_req('0, WORD_ONES, WORD_ONES, WORD_ONES, 1, 1, 1);
        wait_idle();

        // Byte swap on, all-ones seeds so the sums wrap; unused indexes must be ignored
        set_config(1'b1, 1, 1'b1);
        add_req(32'h0102_0304, '0, '0, '0, 1, 1, 1);
        add_req(WORD_ONES, WORD_ONES, WORD_ONES, WORD_ONES, 4, 1, 0);
        add_req(32'h0000_00FF, 32'h0000_FF00, 32'h00FF_0000, 32'hFF00_0000, 4, 0, 1);
        add_req(WORD_ONES, WORD_ONES, WORD_ONES, WORD_ONES, 0, 1, 1);
        add_req($urandom, $urandom, $urandom, $urandom, 4, 1, 1);
        wait_idle();

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0:       set_config(1'b0, 0, 1'b0);
                1:       set_config(1'b1, 2, 1'b0);
                2:       set_config(1'b0, 1, 1'b1);
                3:       set_config(1'b1, 0, 1'b0);
                4:       set_config(1'($urandom), 3, 1'b0);
                default: set_config(1'b0, 2, 1'b0);
            endcase
            target = n_pushed + ITEMS_PER_PHASE;
            while (n_pushed < target) queue_buffer();
            wait_idle();
        end

        $display("Covered %0d requests (%0d with zero count, %0d oversize) and %0d checksums",
                 n_taken, n_zero_count, n_over_count, n_sums_seen);
        $display("over %0d register settings, byte swap on and off, with a long output hold-off.",
                 n_settings + 1);
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
